// ----- rtl/core/gcpb_pkg.sv -----
// shared types, constants and helpers for the glyph coverage pixel blender
// no dependencies
`timescale 1ns / 1ps

package gcpb_pkg;

    localparam int MaskW   = 8;
    localparam int SlotW   = 3;
    localparam int PixW    = 32;
    localparam int ChanW   = 8;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 8;
    localparam int InDataW = 48;

    // mask depth codes
    localparam logic [1:0] DEPTH_1 = 2'd0;
    localparam logic [1:0] DEPTH_2 = 2'd1;
    localparam logic [1:0] DEPTH_4 = 2'd2;
    localparam logic [1:0] DEPTH_8 = 2'd3;

    // target format codes
    localparam logic [1:0] FMT_RGB565   = 2'd0;
    localparam logic [1:0] FMT_RGB888   = 2'd1;
    localparam logic [1:0] FMT_ARGB8565 = 2'd2;
    localparam logic [1:0] FMT_ARGB8888 = 2'd3;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_DEPTH  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_FORMAT = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_RED    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_GREEN  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_BLUE   = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_ALPHA  = 3'd5;

    typedef struct packed {
        logic [1:0]       depth;
        logic [1:0]       format;
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] alpha;
    } t_cfg;

    typedef struct packed {
        logic             nz;
        logic             one_bit;
        logic [ChanW-1:0] alpha;
    } t_cov;

    // floor(x / 255) for x up to 255 * 255
    function automatic logic [ChanW-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        begin
            t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
            div255 = t[15:8];
        end
    endfunction

endpackage

// ----- rtl/core/glyph_coverage_pixel_blender_top.sv -----
// glyph coverage pixel blender: input register, blend logic, result register
// one request per cycle sustained while m_axis_tready holds high
// the blend of one pixel sits between the input and result registers
// reset (synchronous, active low) empties both stages and loads register defaults
// depends on gcpb_pkg, gcpb_coverage and gcpb_pixel
`timescale 1ns / 1ps

module glyph_coverage_pixel_blender_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gcpb_pkg::CfgIdxW-1:0]    i_cfg_addr,
    input  logic [gcpb_pkg::CfgW-1:0]       i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // mask_byte [7:0], pixel_slot [10:8], background [42:11], zero pad
    input  logic [gcpb_pkg::InDataW-1:0]    s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pixel_out [31:0]
    output logic [gcpb_pkg::PixW-1:0]       m_axis_tdata,
    // write_enable [0]
    output logic                            m_axis_tuser
);
    import gcpb_pkg::*;

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [MaskW-1:0]  r_mask_byte;
    logic [SlotW-1:0]  r_pixel_slot;
    logic [PixW-1:0]   r_background;
    logic              r_out_valid;
    logic              r_out_we;
    logic [PixW-1:0]   r_out_pixel;

    logic              adv_out;
    logic              n_we;
    logic [PixW-1:0]   n_pixel;
    t_cov              cov;

    assign adv_out       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || adv_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth  <= DEPTH_1;
            r_cfg.format <= FMT_RGB565;
            r_cfg.red    <= '0;
            r_cfg.green  <= '0;
            r_cfg.blue   <= '0;
            r_cfg.alpha  <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_DEPTH:  r_cfg.depth  <= i_cfg_wdata[1:0];
                REG_FORMAT: r_cfg.format <= i_cfg_wdata[1:0];
                REG_RED:    r_cfg.red    <= i_cfg_wdata;
                REG_GREEN:  r_cfg.green  <= i_cfg_wdata;
                REG_BLUE:   r_cfg.blue   <= i_cfg_wdata;
                REG_ALPHA:  r_cfg.alpha  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_mask_byte  <= s_axis_tdata[7:0];
            r_pixel_slot <= s_axis_tdata[10:8];
            r_background <= s_axis_tdata[42:11];
        end
    end

    gcpb_coverage u_coverage (
        .i_depth     (r_cfg.depth),
        .i_mask_byte (r_mask_byte),
        .i_pixel_slot(r_pixel_slot),
        .o_cov       (cov)
    );

    gcpb_pixel u_pixel (
        .i_cfg         (r_cfg),
        .i_cov         (cov),
        .i_background  (r_background),
        .o_write_enable(n_we),
        .o_pixel       (n_pixel)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_in_valid) begin
            r_out_we    <= n_we;
            r_out_pixel <= n_pixel;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pixel;
    assign m_axis_tuser  = r_out_we;

endmodule

// ----- rtl/core/gcpb_coverage.sv -----
// coverage code extraction and expansion to an 8-bit coverage
// depends on gcpb_pkg
`timescale 1ns / 1ps

module gcpb_coverage (
    input  logic [1:0]                   i_depth,
    input  logic [gcpb_pkg::MaskW-1:0]   i_mask_byte,
    input  logic [gcpb_pkg::SlotW-1:0]   i_pixel_slot,
    output gcpb_pkg::t_cov               o_cov
);
    import gcpb_pkg::*;

    logic       bit1;
    logic [1:0] code2;
    logic [3:0] code4;
    logic [7:0] cov;

    always_comb begin
        bit1  = i_mask_byte[i_pixel_slot];
        code2 = 2'(i_mask_byte >> {i_pixel_slot[1:0], 1'b0});
        code4 = i_pixel_slot[0] ? i_mask_byte[7:4] : i_mask_byte[3:0];
        case (i_depth)
            DEPTH_1: cov = {8{bit1}};
            DEPTH_2: cov = {4{code2}};
            DEPTH_4: cov = {2{code4}};
            DEPTH_8: cov = i_mask_byte;
            default: cov = i_mask_byte;
        endcase
        o_cov.nz      = (cov != 8'd0);
        o_cov.one_bit = (i_depth == DEPTH_1);
        o_cov.alpha   = cov;
    end

endmodule

// ----- rtl/core/gcpb_mix.sv -----
// one channel blend: fg*a/255 + bg*(255-a)/255, each term floored
// depends on gcpb_pkg
`timescale 1ns / 1ps

module gcpb_mix (
    input  logic [gcpb_pkg::ChanW-1:0] i_fg,
    input  logic [gcpb_pkg::ChanW-1:0] i_bg,
    input  logic [gcpb_pkg::ChanW-1:0] i_a,
    output logic [gcpb_pkg::ChanW-1:0] o_mix
);
    import gcpb_pkg::*;

    logic [15:0] fg_prod;
    logic [15:0] bg_prod;
    logic [8:0]  sum;

    always_comb begin
        fg_prod = {8'd0, i_fg} * {8'd0, i_a};
        bg_prod = {8'd0, i_bg} * {8'd0, 8'd255 - i_a};
        sum     = {1'b0, div255(fg_prod)} + {1'b0, div255(bg_prod)};
        o_mix   = sum[7:0];
    end

endmodule

// ----- rtl/core/gcpb_pixel.sv -----
// per-format pixel composition from coverage, text colour and background
// depends on gcpb_pkg and gcpb_mix
`timescale 1ns / 1ps

module gcpb_pixel (
    input  gcpb_pkg::t_cfg             i_cfg,
    input  gcpb_pkg::t_cov             i_cov,
    input  logic [gcpb_pkg::PixW-1:0]  i_background,
    output logic                       o_write_enable,
    output logic [gcpb_pkg::PixW-1:0]  o_pixel
);
    import gcpb_pkg::*;

    logic             is565;
    logic [ChanW-1:0] fg_r, fg_g, fg_b;
    logic [ChanW-1:0] bg_r, bg_g, bg_b;
    logic [ChanW-1:0] mix_r, mix_g, mix_b, mix_a;
    logic [15:0]      colour565;

    always_comb begin
        is565     = (i_cfg.format == FMT_RGB565);
        colour565 = {i_cfg.red[7:3], i_cfg.green[7:2], i_cfg.blue[7:3]};
        fg_r = is565 ? {3'd0, i_cfg.red[7:3]}   : i_cfg.red;
        fg_g = is565 ? {2'd0, i_cfg.green[7:2]} : i_cfg.green;
        fg_b = is565 ? {3'd0, i_cfg.blue[7:3]}  : i_cfg.blue;
        bg_r = is565 ? {3'd0, i_background[15:11]} : i_background[23:16];
        bg_g = is565 ? {2'd0, i_background[10:5]}  : i_background[15:8];
        bg_b = is565 ? {3'd0, i_background[4:0]}   : i_background[7:0];
    end

    gcpb_mix u_mix_r (.i_fg(fg_r), .i_bg(bg_r), .i_a(i_cov.alpha), .o_mix(mix_r));
    gcpb_mix u_mix_g (.i_fg(fg_g), .i_bg(bg_g), .i_a(i_cov.alpha), .o_mix(mix_g));
    gcpb_mix u_mix_b (.i_fg(fg_b), .i_bg(bg_b), .i_a(i_cov.alpha), .o_mix(mix_b));
    // output alpha a + bgA*(255-a)/255 equals a blend with 255 as foreground
    gcpb_mix u_mix_a (
        .i_fg (8'd255),
        .i_bg (i_background[31:24]),
        .i_a  (i_cov.alpha),
        .o_mix(mix_a)
    );

    always_comb begin
        o_write_enable = i_cov.nz;
        o_pixel        = '0;
        if (i_cov.nz) begin
            case (i_cfg.format)
                FMT_RGB565: begin
                    if (i_cov.one_bit) begin
                        o_pixel = {16'd0, colour565};
                    end else begin
                        o_pixel = {16'd0, mix_r[4:0], mix_g[5:0], mix_b[4:0]};
                    end
                end
                FMT_RGB888: begin
                    if (i_cov.one_bit) begin
                        o_pixel = {8'd0, i_cfg.red, i_cfg.green, i_cfg.blue};
                    end else begin
                        o_pixel = {8'd0, mix_r, mix_g, mix_b};
                    end
                end
                FMT_ARGB8565: begin
                    o_pixel = {8'd0, (i_cov.one_bit ? i_cfg.alpha : i_cov.alpha), colour565};
                end
                default: begin
                    if (i_cov.one_bit) begin
                        o_pixel = {i_cfg.alpha, i_cfg.red, i_cfg.green, i_cfg.blue};
                    end else begin
                        o_pixel = {mix_a, mix_r, mix_g, mix_b};
                    end
                end
            endcase
        end
    end

endmodule
